FILE: rtl/isqrr_pkg.sv
// Shared constants for the rounded integer square root block.
`default_nettype none

package isqrr_pkg;

  localparam int unsigned RADICAND_W  = 32;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned ROOT_W      = 17;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned ROOT_BITS_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_DOWN    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UP      = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/isqrr_cell.sv
// One restoring square root step: bring down a bit pair, trial subtract, register.
`default_nettype none

module isqrr_cell
  import isqrr_pkg::*;
#(
  parameter int unsigned ROOT_BITS = ROOT_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [2*ROOT_BITS-1:0] rad_i,
  input  wire logic [ROOT_BITS-1:0]   root_i,
  input  wire logic [ROOT_BITS+1:0]   rem_i,
  input  wire logic [MODE_W-1:0]      mode_i,
  output logic                        valid_o,
  output logic [2*ROOT_BITS-1:0]      rad_o,
  output logic [ROOT_BITS-1:0]        root_o,
  output logic [ROOT_BITS+1:0]        rem_o,
  output logic [MODE_W-1:0]           mode_o
);

  localparam int unsigned RW = ROOT_BITS + 2;

  logic [RW+1:0]          cur;
  logic [RW+1:0]          trial;
  logic [RW+1:0]          diff;
  logic                   ge;
  logic                   valid_q;
  logic [2*ROOT_BITS-1:0] rad_q;
  logic [ROOT_BITS-1:0]   root_q;
  logic [RW-1:0]          rem_q;
  logic [MODE_W-1:0]      mode_q;

  assign cur   = {rem_i, rad_i[2*ROOT_BITS-1 -: 2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge    = (cur >= trial);
  assign diff  = cur - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= {rad_i[2*ROOT_BITS-3:0], 2'b00};
      root_q <= {root_i[ROOT_BITS-2:0], ge};
      rem_q  <= ge ? diff[RW-1:0] : cur[RW-1:0];
      mode_q <= mode_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign root_o  = root_q;
  assign rem_o   = rem_q;
  assign mode_o  = mode_q;

endmodule

`default_nettype wire

FILE: rtl/isqrr_round.sv
// Final rounding stage and output register.
`default_nettype none

module isqrr_round
  import isqrr_pkg::*;
#(
  parameter int unsigned ROOT_BITS = ROOT_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [ROOT_BITS-1:0] root_i,
  input  wire logic [ROOT_BITS+1:0] rem_i,
  input  wire logic [MODE_W-1:0]    mode_i,
  output logic                      valid_o,
  output logic [ROOT_W-1:0]         root_o
);

  logic                        inc;
  logic [ROOT_BITS:0]          sum;
  logic [ROOT_BITS+ROOT_W:0]   wide;
  logic                        valid_q;
  logic [ROOT_W-1:0]           root_q;

  always_comb begin
    case (mode_i)
      MODE_NEAREST: inc = (rem_i > {2'b00, root_i});
      MODE_UP:      inc = (rem_i != '0);
      default:      inc = 1'b0;
    endcase
  end

  assign sum  = {1'b0, root_i} + {{ROOT_BITS{1'b0}}, inc};
  assign wide = {{ROOT_W{1'b0}}, sum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= wide[ROOT_W-1:0];
    end
  end

  assign valid_o = valid_q;
  assign root_o  = root_q;

endmodule

`default_nettype wire

FILE: rtl/integer_square_root_rounded_top.sv
// Rounded integer square root: a row of step cells followed by a rounding stage.
// Each item passes through one register per cell and then the rounding register on its way to the output.
// Throughput: one item per cycle; the whole row advances whenever the output register is
// empty or being taken, so a stall at the output holds every cell.
// Reset clears the valid bit of every cell and of the output; data registers are not reset.
`default_nettype none

module integer_square_root_rounded_top
  import isqrr_pkg::*;
#(
  parameter int unsigned ROOT_BITS = ROOT_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] radicand
  input  wire logic [MODE_W-1:0]      s_axis_tuser,  // [1:0] rounding_mode
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // [16:0] root, rest zero
);

  localparam int unsigned RAD_W = 2 * ROOT_BITS;

  logic                   adv;
  logic [RAD_W+RADICAND_W-1:0] rad_ext;
  logic                   valid_w [ROOT_BITS+1];
  logic [RAD_W-1:0]       rad_w   [ROOT_BITS];
  logic [ROOT_BITS-1:0]   root_w  [ROOT_BITS+1];
  logic [ROOT_BITS+1:0]   rem_w   [ROOT_BITS+1];
  logic [MODE_W-1:0]      mode_w  [ROOT_BITS+1];
  logic [ROOT_W-1:0]      root_out;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  assign rad_ext   = {{RAD_W{1'b0}}, s_axis_tdata};
  assign valid_w[0] = s_axis_tvalid;
  assign rad_w[0]   = rad_ext[RAD_W-1:0];
  assign root_w[0]  = '0;
  assign rem_w[0]   = '0;
  assign mode_w[0]  = s_axis_tuser;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_cell
    if (k < ROOT_BITS - 1) begin : g_mid
      isqrr_cell #(
        .ROOT_BITS(ROOT_BITS)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (adv),
        .valid_i(valid_w[k]),
        .rad_i  (rad_w[k]),
        .root_i (root_w[k]),
        .rem_i  (rem_w[k]),
        .mode_i (mode_w[k]),
        .valid_o(valid_w[k+1]),
        .rad_o  (rad_w[k+1]),
        .root_o (root_w[k+1]),
        .rem_o  (rem_w[k+1]),
        .mode_o (mode_w[k+1])
      );
    end else begin : g_last
      isqrr_cell #(
        .ROOT_BITS(ROOT_BITS)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (adv),
        .valid_i(valid_w[k]),
        .rad_i  (rad_w[k]),
        .root_i (root_w[k]),
        .rem_i  (rem_w[k]),
        .mode_i (mode_w[k]),
        .valid_o(valid_w[k+1]),
        .rad_o  (),
        .root_o (root_w[k+1]),
        .rem_o  (rem_w[k+1]),
        .mode_o (mode_w[k+1])
      );
    end
  end

  isqrr_round #(
    .ROOT_BITS(ROOT_BITS)
  ) u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(valid_w[ROOT_BITS]),
    .root_i (root_w[ROOT_BITS]),
    .rem_i  (rem_w[ROOT_BITS]),
    .mode_i (mode_w[ROOT_BITS]),
    .valid_o(m_axis_tvalid),
    .root_o (root_out)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-ROOT_W){1'b0}}, root_out};

endmodule

`default_nettype wire

FILE: tb/integer_square_root_rounded_top_test.sv
// Self-checking testbench for the rounded integer square root stream block.
`default_nettype none

module integer_square_root_rounded_top_test
  import isqrr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROOT_BITS      = ROOT_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned QUIET_ITEMS    = 300;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned REPORT_LIMIT   = 10;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [31:0] radicand
  logic [MODE_W-1:0]      s_axis_tuser = '0;   // [1:0] rounding_mode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [16:0] root, rest zero

  logic [OUT_TDATA_W-1:0] pending_roots[$];
  bit                     idling = 1'b1;
  int unsigned            items_sent;
  int unsigned            roots_checked;
  int unsigned            mismatch_count;
  int unsigned            cycle_count;
  int unsigned            mode_count[4];

  integer_square_root_rounded_top #(
    .ROOT_BITS(ROOT_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [ROOT_W-1:0] predict_root(input logic [RADICAND_W-1:0] value,
                                                     input logic [MODE_W-1:0] mode);
    logic [33:0]       rem;
    logic [33:0]       trial;
    logic [ROOT_W-1:0] root;
    rem  = '0;
    root = '0;
    for (int step = ROOT_BITS - 1; step >= 0; step--) begin
      rem   = {rem[31:0], value[2*step +: 2]};
      root  = root << 1;
      trial = (34'(root) << 1) | 34'd1;
      if (rem >= trial) begin
        rem     = rem - trial;
        root[0] = 1'b1;
      end
    end
    case (mode)
      MODE_NEAREST: begin
        if (rem > 34'(root)) root = root + 1'b1;
      end
      MODE_UP: begin
        if (rem != '0) root = root + 1'b1;
      end
      default: begin
      end
    endcase
    return root;
  endfunction

  // Called at a falling edge; returns at a falling edge with tvalid still high.
  task automatic send_item(input logic [RADICAND_W-1:0] value, input logic [MODE_W-1:0] mode);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_roots.push_back(OUT_TDATA_W'(predict_root(value, mode)));
    items_sent++;
    mode_count[mode]++;
    @(negedge clk_i);
  endtask

  task automatic test_extremes();
    for (int m = 0; m < 4; m++) begin
      send_item(32'h0000_0000, MODE_W'(m));
      send_item(32'hFFFF_FFFF, MODE_W'(m));
    end
  endtask

  task automatic test_rounding_boundaries();
    send_item(32'd2, MODE_NEAREST);
    send_item(32'd3, MODE_NEAREST);
    send_item(32'd4, MODE_UP);
    send_item(32'd5, MODE_UP);
    send_item(32'hFFFF_0000, MODE_NEAREST);
    send_item(32'hFFFF_0001, MODE_NEAREST);
    send_item(32'hFFFE_0001, MODE_UP);
    send_item(32'hFFFE_0002, MODE_UP);
    send_item(32'hFFFE_0002, MODE_SPARE);
  endtask

  task automatic test_random_values();
    logic [RADICAND_W-1:0] value;
    logic [RADICAND_W-1:0] k;
    int unsigned           pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) idling = 1'b0;
      pick = $urandom_range(0, 3);
      case (pick)
        0: value = $urandom();
        1: begin
          k = $urandom_range(0, 65535);
          value = k * k;
          case ($urandom_range(0, 4))
            0: value = value - 1;
            1: value = value + 1;
            2: value = value + k;
            3: value = value + k + 1;
            default: begin
            end
          endcase
        end
        2: value = $urandom_range(0, 300);
        default: value = $urandom() >> $urandom_range(0, 31);
      endcase
      send_item(value, MODE_W'($urandom_range(0, 3)));
    end
  endtask

  always @(negedge clk_i) begin
    if (idling && rst_ni && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    logic [OUT_TDATA_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_roots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected root %0d with nothing pending", m_axis_tdata);
      end else begin
        want = pending_roots.pop_front();
        roots_checked++;
        if (m_axis_tdata !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("root mismatch: expected %0d (tdata %h), got %0d (tdata %h)",
                     want[ROOT_W-1:0], want, m_axis_tdata[ROOT_W-1:0], m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_rounding_boundaries();
    test_random_values();
    s_axis_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (ROOT_BITS + 8) @(posedge clk_i);
    $display("sent %0d radicands (down %0d, nearest %0d, up %0d, spare code %0d)",
             items_sent, mode_count[MODE_DOWN], mode_count[MODE_NEAREST],
             mode_count[MODE_UP], mode_count[MODE_SPARE]);
    $display("checked %0d roots, %0d mismatches", roots_checked, mismatch_count);
    if (mismatch_count == 0 && pending_roots.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
